FILE: hdl/prd_pkg.sv
// ----------------------------------------------------------------------------
// prd_pkg: shared types and codes for the priority ring deque
// Item formats, action and status codes, entry layout and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package prd_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int TAG_W         = 16;
    localparam int PRIO_W        = 8;
    localparam int OCC_W         = 4;

    localparam logic [PRIO_W-1:0] PRIO_BACK  = PRIO_W'(0);
    localparam logic [PRIO_W-1:0] PRIO_FRONT = PRIO_W'(10);

    localparam logic [2:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_INSERT     = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [2:0]        action;
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] priority_req;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [TAG_W-1:0]  out_tag;
        logic [PRIO_W-1:0] out_priority;
        logic [OCC_W-1:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [PRIO_W-1:0] prio;
    } t_entry;

endpackage

`default_nettype wire

FILE: hdl/priority_ring_deque.sv
// ----------------------------------------------------------------------------
// priority_ring_deque: ring deque with sorted insert
// Entries of tag and priority held in one synchronous memory; push and pop
// at both ends, and priority insert that shifts the higher run frontward.
// ----------------------------------------------------------------------------
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+----------------------
//  input    | i_in_valid   | o_in_stall   | i_in_item  (t_in_item)
//  output   | o_out_valid  | i_out_stall  | o_out_item (t_out_item)
//
//  Push back, push front, insert into an empty deque, rejected and unknown
//  actions are answered from the idle state, without a memory read.
//  Pop front and pop back: one memory read, then the result in S_POP.
//  Priority insert otherwise: each higher entry moves one slot frontward,
//  one memory read and one write per cycle, then the new entry is written.
//  One item at a time; the input stalls while an item is in work or while
//  an unaccepted result holds the output register.
//  Reset clears head, count and state; memory contents start undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_ring_deque
    import prd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;

    function automatic logic [IW-1:0] slot_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] slot_next(input logic [IW-1:0] s);
        return (s == IW'(DEPTH - 1)) ? '0 : s + IW'(1);
    endfunction

    function automatic logic [IW-1:0] slot_prev(input logic [IW-1:0] s);
        return (s == '0) ? IW'(DEPTH - 1) : s - IW'(1);
    endfunction

    function automatic logic [OCC_W-1:0] occ_of(input logic [CW-1:0] c);
        logic [CW+OCC_W-1:0] wide;
        wide = {{OCC_W{1'b0}}, c};
        return wide[OCC_W-1:0];
    endfunction

    t_entry            mem [DEPTH];
    t_entry            r_q;

    logic [2:0]        r_state, n_state;
    logic [IW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_k, n_k;
    logic [IW-1:0]     r_src, n_src;
    logic [TAG_W-1:0]  r_tag, n_tag;
    logic [PRIO_W-1:0] r_prio, n_prio;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              in_fire;
    logic              full, empty;
    logic              rd_en, we;
    logic [IW-1:0]     rd_addr, wr_addr;
    t_entry            wr_data;
    logic              load_out;
    t_out_item         out_d;
    logic [CW-1:0]     k_inc;

    assign o_in_stall  = (r_state != S_IDLE) | (r_out_valid & i_out_stall);
    assign in_fire     = i_in_valid & ~o_in_stall;
    assign full        = (r_cnt >= CW'(DEPTH));
    assign empty       = (r_cnt == '0);
    assign k_inc       = r_k + CW'(1);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_src    = r_src;
        n_tag    = r_tag;
        n_prio   = r_prio;
        rd_en    = 1'b0;
        rd_addr  = r_head;
        we       = 1'b0;
        wr_addr  = r_head;
        wr_data  = '0;
        load_out = 1'b0;
        out_d    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_tag  = i_in_item.tag;
                    n_prio = i_in_item.priority_req;
                    unique case (i_in_item.action)
                        ACT_PUSH_BACK: begin
                            load_out = 1'b1;
                            if (full) begin
                                out_d.status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                wr_addr = slot_add(r_head, r_cnt);
                                wr_data = '{tag: i_in_item.tag, prio: PRIO_BACK};
                                n_cnt   = r_cnt + CW'(1);
                            end
                        end
                        ACT_PUSH_FRONT: begin
                            load_out = 1'b1;
                            if (full) begin
                                out_d.status = ST_FULL;
                            end else begin
                                we      = 1'b1;
                                wr_addr = slot_prev(r_head);
                                wr_data = '{tag: i_in_item.tag, prio: PRIO_FRONT};
                                n_head  = slot_prev(r_head);
                                n_cnt   = r_cnt + CW'(1);
                            end
                        end
                        ACT_POP_FRONT: begin
                            if (empty) begin
                                load_out     = 1'b1;
                                out_d.status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_head  = slot_next(r_head);
                                n_cnt   = r_cnt - CW'(1);
                                n_state = S_POP;
                            end
                        end
                        ACT_POP_BACK: begin
                            if (empty) begin
                                load_out     = 1'b1;
                                out_d.status = ST_EMPTY;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = slot_add(r_head, r_cnt - CW'(1));
                                n_cnt   = r_cnt - CW'(1);
                                n_state = S_POP;
                            end
                        end
                        ACT_INSERT: begin
                            if (full) begin
                                load_out     = 1'b1;
                                out_d.status = ST_FULL;
                            end else if (empty) begin
                                load_out = 1'b1;
                                we       = 1'b1;
                                wr_addr  = slot_prev(r_head);
                                wr_data  = '{tag: i_in_item.tag,
                                             prio: i_in_item.priority_req};
                                n_head   = slot_prev(r_head);
                                n_cnt    = r_cnt + CW'(1);
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_k     = '0;
                                n_src   = r_head;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                load_out           = 1'b1;
                out_d.out_tag      = r_q.tag;
                out_d.out_priority = r_q.prio;
                n_state            = S_IDLE;
            end
            S_SCAN: begin
                if (r_q.prio > r_prio) begin
                    // shift this entry one slot toward the front
                    we      = 1'b1;
                    wr_addr = slot_prev(r_src);
                    wr_data = r_q;
                    if (k_inc < r_cnt) begin
                        rd_en   = 1'b1;
                        rd_addr = slot_next(r_src);
                        n_k     = k_inc;
                        n_src   = slot_next(r_src);
                    end else begin
                        n_state = S_PLACE;
                    end
                end else begin
                    load_out = 1'b1;
                    we       = 1'b1;
                    wr_addr  = slot_prev(r_src);
                    wr_data  = '{tag: r_tag, prio: r_prio};
                    n_head   = slot_prev(r_head);
                    n_cnt    = r_cnt + CW'(1);
                    n_state  = S_IDLE;
                end
            end
            S_PLACE: begin
                load_out = 1'b1;
                we       = 1'b1;
                wr_addr  = r_src;
                wr_data  = '{tag: r_tag, prio: r_prio};
                n_head   = slot_prev(r_head);
                n_cnt    = r_cnt + CW'(1);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        out_d.occupancy = occ_of(n_cnt);
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_src  <= n_src;
        r_tag  <= n_tag;
        r_prio <= n_prio;
        if (load_out) begin
            r_out <= out_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the priority ring deque
// Drives push, pop, priority insert and unused actions through the
// valid/stall input channel, predicts every result with a behavioral copy
// of the deque and checks each result field by field, under several
// sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------

import prd_pkg::*;

class deque_tracker;
    logic [TAG_W-1:0]  tag_slot [DEPTH_DEFAULT];
    logic [PRIO_W-1:0] prio_slot[DEPTH_DEFAULT];
    int                head;
    int                count;
    int                errors;
    t_out_item         expected[$];

    function new();
        head   = 0;
        count  = 0;
        errors = 0;
    endfunction

    function t_out_item predict(t_in_item req);
        t_out_item rsp;
        int        k;
        int        src;
        int        s;
        rsp = '0;
        rsp.status = ST_OK;
        case (req.action)
            ACT_PUSH_BACK: begin
                if (count >= DEPTH_DEFAULT) begin
                    rsp.status = ST_FULL;
                end else begin
                    s = (head + count) % DEPTH_DEFAULT;
                    tag_slot[s]  = req.tag;
                    prio_slot[s] = PRIO_BACK;
                    count++;
                end
            end
            ACT_PUSH_FRONT: begin
                if (count >= DEPTH_DEFAULT) begin
                    rsp.status = ST_FULL;
                end else begin
                    head = (head + DEPTH_DEFAULT - 1) % DEPTH_DEFAULT;
                    tag_slot[head]  = req.tag;
                    prio_slot[head] = PRIO_FRONT;
                    count++;
                end
            end
            ACT_POP_FRONT: begin
                if (count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    rsp.out_tag      = tag_slot[head];
                    rsp.out_priority = prio_slot[head];
                    head = (head + 1) % DEPTH_DEFAULT;
                    count--;
                end
            end
            ACT_POP_BACK: begin
                if (count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    s = (head + count - 1) % DEPTH_DEFAULT;
                    rsp.out_tag      = tag_slot[s];
                    rsp.out_priority = prio_slot[s];
                    count--;
                end
            end
            ACT_INSERT: begin
                if (count >= DEPTH_DEFAULT) begin
                    rsp.status = ST_FULL;
                end else begin
                    k = 0;
                    while (k < count &&
                           prio_slot[(head + k) % DEPTH_DEFAULT] > req.priority_req)
                        k++;
                    for (int i = 0; i < k; i++) begin
                        src = (head + i) % DEPTH_DEFAULT;
                        s   = (src + DEPTH_DEFAULT - 1) % DEPTH_DEFAULT;
                        tag_slot[s]  = tag_slot[src];
                        prio_slot[s] = prio_slot[src];
                    end
                    head = (head + DEPTH_DEFAULT - 1) % DEPTH_DEFAULT;
                    s = (head + k) % DEPTH_DEFAULT;
                    tag_slot[s]  = req.tag;
                    prio_slot[s] = req.priority_req;
                    count++;
                end
            end
            default: begin
            end
        endcase
        rsp.occupancy = OCC_W'(count);
        return rsp;
    endfunction

    function void note_request(t_in_item req);
        expected.push_back(predict(req));
    endfunction

    function void flag(string what, int want, int got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
    endfunction

    function void check_response(t_out_item got);
        t_out_item want;
        if (expected.size() == 0) begin
            flag("unexpected item", 0, got);
            return;
        end
        want = expected.pop_front();
        if (got.status !== want.status)
            flag("status", want.status, got.status);
        if (got.out_tag !== want.out_tag)
            flag("out_tag", want.out_tag, got.out_tag);
        if (got.out_priority !== want.out_priority)
            flag("out_priority", want.out_priority, got.out_priority);
        if (got.occupancy !== want.occupancy)
            flag("occupancy", want.occupancy, got.occupancy);
    endfunction

    function int pending();
        return expected.size();
    endfunction
endclass

module tb_top;

    localparam int QUIET_LIMIT = 3000;
    localparam int LONG_HOLD   = 80;
    localparam int TAIL_CYCLES = 20;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_item;

    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;
    bit           long_hold_req  = 1'b0;
    int           hold_left      = 0;
    int           quiet_cycles   = 0;
    bit           filling        = 1'b1;
    deque_tracker tracker;

    priority_ring_deque u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item)
    );

    always #5 clk = ~clk;

    function automatic t_in_item make_request(logic [2:0] act, logic [TAG_W-1:0] tag,
                                              logic [PRIO_W-1:0] prio);
        t_in_item req;
        req.action       = act;
        req.tag          = tag;
        req.priority_req = prio;
        return req;
    endfunction

    function automatic t_in_item random_request();
        t_in_item req;
        int       push_pct;
        if ($urandom_range(11) == 0)
            filling = ~filling;
        push_pct = filling ? 70 : 30;
        req.tag  = TAG_W'($urandom);
        case ($urandom_range(3))
            0: req.priority_req = PRIO_BACK;
            1: req.priority_req = PRIO_FRONT;
            2: req.priority_req = PRIO_W'($urandom_range(20));
            default: req.priority_req = PRIO_W'($urandom);
        endcase
        if ($urandom_range(99) < 5) begin
            req.action = 3'($urandom_range(7, 5));
        end else if ($urandom_range(99) < push_pct) begin
            case ($urandom_range(2))
                0: req.action = ACT_PUSH_BACK;
                1: req.action = ACT_PUSH_FRONT;
                default: req.action = ACT_INSERT;
            endcase
        end else begin
            req.action = $urandom_range(1) ? ACT_POP_FRONT : ACT_POP_BACK;
        end
        return req;
    endfunction

    task automatic send_item(input t_in_item req);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (o_in_stall)
            @(posedge clk);
        tracker.note_request(req);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk) begin
        if (long_hold_req) begin
            hold_left     = LONG_HOLD;
            long_hold_req = 1'b0;
        end
        if (rst_n && o_out_valid && !out_stall)
            tracker.check_response(o_out_item);
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_in_item plan[$];
        tracker = new();

        plan.push_back(make_request(ACT_POP_FRONT, 16'h0000, 8'h00));
        plan.push_back(make_request(ACT_POP_BACK, 16'hFFFF, 8'hFF));
        plan.push_back(make_request(ACT_PUSH_BACK, 16'hFFFF, 8'hFF));
        plan.push_back(make_request(ACT_PUSH_FRONT, 16'h0000, 8'h00));
        plan.push_back(make_request(ACT_INSERT, 16'hAAAA, 8'hFF));
        plan.push_back(make_request(ACT_INSERT, 16'h5555, 8'h00));
        plan.push_back(make_request(ACT_INSERT, 16'h1234, PRIO_FRONT));
        plan.push_back(make_request(3'd5, 16'h0F0F, 8'h0F));
        plan.push_back(make_request(3'd6, 16'hF0F0, 8'hF0));
        plan.push_back(make_request(3'd7, 16'hFFFF, 8'hFF));
        plan.push_back(make_request(ACT_PUSH_BACK, 16'h8001, 8'h7F));
        plan.push_back(make_request(ACT_PUSH_FRONT, 16'h7FFE, 8'h80));
        plan.push_back(make_request(ACT_INSERT, 16'hBEEF, PRIO_FRONT));
        plan.push_back(make_request(ACT_PUSH_BACK, 16'h1111, 8'h00));
        plan.push_back(make_request(ACT_PUSH_FRONT, 16'h2222, 8'h00));
        plan.push_back(make_request(ACT_INSERT, 16'h3333, 8'hFF));
        for (int i = 0; i < 8; i++)
            plan.push_back(make_request(i[0] ? ACT_POP_BACK : ACT_POP_FRONT, 16'h0, 8'h0));
        plan.push_back(make_request(ACT_POP_BACK, 16'h0, 8'h0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i]);
        drain_results();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (int n = 0; n < 100; n++) begin
                if (phase == 0 && n == 40)
                    long_hold_req = 1'b1;
                send_item(random_request());
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
